[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, clk, rst_n, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, clk, rst_n, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, clk, rst_n, msg)
`define ASSERT_NEVER(label, cond, clk, rst_n, msg)
`endif
`endif

[hw/rtl/smnf_pkg.sv]
// Package of the sliding median normal filter: sizes, entry type and cell control.
`timescale 1ns / 1ps
`default_nettype none
package smnf_pkg;

  localparam int NORM_W      = 16;
  localparam int CURV_W      = 16;
  localparam int WINDOW_LEN  = 5;
  localparam int MEDIAN_RANK = WINDOW_LEN / 2;
  localparam int IDX_W       = $clog2(WINDOW_LEN);
  localparam int ENTRY_W     = 3 * NORM_W + CURV_W;

  // One window entry: curvature in the top bits, then z, y and x.
  typedef struct packed {
    logic        [CURV_W-1:0] curvature;
    logic signed [NORM_W-1:0] z;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] x;
  } entry_t;

  typedef entry_t [WINDOW_LEN-1:0]              entry_vec_t;
  typedef logic   [WINDOW_LEN-1:0][CURV_W-1:0]  curv_vec_t;

  // Update command broadcast to every cell of the window.
  typedef struct packed {
    logic load_all;  // first normal with nonzero curvature: every cell takes a copy
    logic shift;     // later normals with nonzero curvature: cells move one place older
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/smnf_in_if.sv]
// Input channel interface: one surface normal per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface smnf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [smnf_pkg::NORM_W-1:0]  norm_x_in;
  logic signed [smnf_pkg::NORM_W-1:0]  norm_y_in;
  logic signed [smnf_pkg::NORM_W-1:0]  norm_z_in;
  logic        [smnf_pkg::CURV_W-1:0]  curvature_in;

  modport source (output valid, output norm_x_in, output norm_y_in, output norm_z_in,
                  output curvature_in, input ready);
  modport sink   (input valid, input norm_x_in, input norm_y_in, input norm_z_in,
                  input curvature_in, output ready);
endinterface
`default_nettype wire

[hw/rtl/smnf_out_if.sv]
// Output channel interface: one filtered normal per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface smnf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [smnf_pkg::NORM_W-1:0]  norm_x_out;
  logic signed [smnf_pkg::NORM_W-1:0]  norm_y_out;
  logic signed [smnf_pkg::NORM_W-1:0]  norm_z_out;
  logic        [smnf_pkg::CURV_W-1:0]  curvature_out;

  modport source (output valid, output norm_x_out, output norm_y_out, output norm_z_out,
                  output curvature_out, input ready);
  modport sink   (input valid, input norm_x_out, input norm_y_out, input norm_z_out,
                  input curvature_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/sliding_median_normal_filter_core.sv]
// Top level of the sliding median normal filter: cell chain, control and output stage.
// The filter takes one surface normal per clock cycle and gives, for each normal with
// nonzero curvature, the entry of the last five whose curvature is the median (of equal
// curvatures, the newer entry ranks lower); the first such normal after reset fills the
// window and comes back unchanged. A normal with zero curvature is taken and dropped
// without a result. The window takes a normal at the edge of its transfer in, the
// cells rank the new window in the following cycle and the median is loaded into the
// output register once that register is free. The shift of one normal overlaps the
// ranking of the previous one, so the throughput is one normal per cycle for as long as
// the output side takes results; while a result waits in the output register and the
// next median is ready, the input is held off.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sliding_median_normal_filter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  smnf_in_if.sink    norm_i,
  smnf_out_if.source median_o
);
  import smnf_pkg::*;

  logic                  primed_q;
  logic                  primed_d;
  logic                  pend_q;
  logic                  pend_d;
  logic                  in_xfer;
  logic                  item_ok;
  logic                  advance;
  logic                  out_free;
  cell_ctrl_t            cell_ctrl;
  entry_t                new_entry;
  entry_vec_t            entries;
  curv_vec_t             curv_all;
  logic [WINDOW_LEN-1:0] sel;

  // Input transfer and the window command it causes.
  assign in_xfer  = norm_i.valid && norm_i.ready;
  assign item_ok  = in_xfer && (norm_i.curvature_in != '0);
  assign advance  = pend_q && out_free;
  assign norm_i.ready = !pend_q || out_free;

  assign cell_ctrl.load_all = item_ok && !primed_q;
  assign cell_ctrl.shift    = item_ok && primed_q;

  assign new_entry.x         = norm_i.norm_x_in;
  assign new_entry.y         = norm_i.norm_y_in;
  assign new_entry.z         = norm_i.norm_z_in;
  assign new_entry.curvature = norm_i.curvature_in;

  // Primed flag and the flag for a window awaiting its median.
  assign primed_d = primed_q || item_ok;
  assign pend_d   = item_ok ? 1'b1 : (advance ? 1'b0 : pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      primed_q <= primed_d;
      pend_q   <= pend_d;
    end
  end

  // Chain of cells, newest at index zero.
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    assign curv_all[i] = entries[i].curvature;

    smnf_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .new_entry_i  (new_entry),
      .prev_entry_i ((i == 0) ? new_entry : entries[(i == 0) ? 0 : i - 1]),
      .idx_i        (IDX_W'(i)),
      .curv_all_i   (curv_all),
      .entry_o      (entries[i]),
      .sel_o        (sel[i])
    );
  end

  // Median selection into the output register.
  smnf_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .sel_i     (sel),
    .entries_i (entries),
    .free_o    (out_free),
    .out_o     (median_o)
  );

  // Checks on the control logic.
  `ASSERT_NEVER(a_ctrl_excl, cell_ctrl.load_all && cell_ctrl.shift, clk_i, rst_ni, "load and shift together")
  `ASSERT_CLK(a_load_primes, cell_ctrl.load_all |=> primed_q, clk_i, rst_ni, "window not primed after load")
  `ASSERT_CLK(a_pend_held, (pend_q && !out_free) |-> !norm_i.ready, clk_i, rst_ni, "input taken over pending window")
  `ASSERT_CLK(a_out_from_pend, $rose(median_o.valid) |-> $past(pend_q), clk_i, rst_ni, "result without pending window")

endmodule
`default_nettype wire

[hw/rtl/smnf_cell.sv]
// One window cell: holds an entry, passes it to the older neighbour and ranks it.
`timescale 1ns / 1ps
`default_nettype none
module smnf_cell (
  input  logic                           clk_i,
  input  smnf_pkg::cell_ctrl_t           ctrl_i,
  input  smnf_pkg::entry_t               new_entry_i,
  input  smnf_pkg::entry_t               prev_entry_i,
  input  logic [smnf_pkg::IDX_W-1:0]     idx_i,
  input  smnf_pkg::curv_vec_t            curv_all_i,
  output smnf_pkg::entry_t               entry_o,
  output logic                           sel_o
);
  import smnf_pkg::*;

  entry_t           entry_q;
  entry_t           entry_d;
  logic [IDX_W-1:0] rank;

  // Entry update: copy on priming, take the newer neighbour's entry on a shift.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_all) begin
      entry_d = new_entry_i;
    end else if (ctrl_i.shift) begin
      entry_d = prev_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Rank: entries with smaller curvature, or equal curvature and newer, count below.
  always_comb begin
    int cnt;
    cnt = 0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if ((curv_all_i[j] < entry_q.curvature) ||
          ((curv_all_i[j] == entry_q.curvature) && (j < int'(idx_i)))) begin
        cnt = cnt + 1;
      end
    end
    rank = IDX_W'(cnt);
  end

  assign sel_o   = (rank == IDX_W'(MEDIAN_RANK));
  assign entry_o = entry_q;

endmodule
`default_nettype wire

[hw/rtl/smnf_out_stage.sv]
// Output register: picks the median cell's entry and holds it until transferred.
`timescale 1ns / 1ps
`default_nettype none
module smnf_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [smnf_pkg::WINDOW_LEN-1:0]    sel_i,
  input  smnf_pkg::entry_vec_t               entries_i,
  output logic                               free_o,
  smnf_out_if.source                         out_o
);
  import smnf_pkg::*;

  entry_t             out_q;
  entry_t             out_d;
  logic               valid_q;
  logic               valid_d;
  logic [ENTRY_W-1:0] pick;

  // Exactly one cell flags itself as the median; AND-OR select its entry.
  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      pick = pick | (entries_i[i] & {ENTRY_W{sel_i[i]}});
    end
  end

  assign free_o  = !valid_q || out_o.ready;
  assign out_d   = load_i ? entry_t'(pick) : out_q;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid         = valid_q;
  assign out_o.norm_x_out    = out_q.x;
  assign out_o.norm_y_out    = out_q.y;
  assign out_o.norm_z_out    = out_q.z;
  assign out_o.curvature_out = out_q.curvature;

endmodule
`default_nettype wire
